// File: design/message_segmenter_with_header_unit_macros.svh
// Assertion macros used by the checker file of the segmenter.
`ifndef MESSAGE_SEGMENTER_WITH_HEADER_UNIT_MACROS_SVH
`define MESSAGE_SEGMENTER_WITH_HEADER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define MSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define MSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/msu_pkg.sv
package msu_pkg;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned BYTE_W = 8;

  // Flag bits of the first header byte.
  localparam logic [BYTE_W-1:0] FLAG_FIRST = 8'h01;
  localparam logic [BYTE_W-1:0] FLAG_LAST  = 8'h02;
  localparam logic [BYTE_W-1:0] HDR_BYTES  = 8'd2;

  localparam logic [BYTE_W-1:0] PKT_SIZE_RESET = 8'd20;

  // Request types.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TOO_SMALL = 2'd1;
  localparam logic [1:0] STAT_OVERRUN  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MSG_LEN  = 1'b0;
  localparam logic CFG_PKT_SIZE = 1'b1;

  // Result queue.
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_header;
    logic              packet_end;
    logic [1:0]        status;
    logic              run_last;
  } result_t;

endpackage

// File: design/message_segmenter_with_header_unit.sv
// Message segmenter with a two-byte packet header. A start transfer (req_type 0) loads
// message_length and restarts the sequence number; payload transfers (req_type 1) carry one
// byte each, and the block cuts them into packets of at most packet_size bytes, each opened
// by a flags byte (bit0 first packet, bit1 last packet) and an 8-bit wrapping sequence byte.
// Every input transfer produces zero to three result transfers. Results wait in a four-entry
// queue and leave it on the output channel one per cycle while out_stall is low. The input
// is taken whenever at most one result is queued, so a stream of mid-packet payload bytes
// runs at one byte per cycle when the output does not stall, while the first byte of a
// packet (header plus payload, three results) holds the input while more than one result
// is queued. An empty message gives a header-only packet; packet_size of 2 or less gives a
// single status 1 result, and a byte beyond the message length gives a single status 2
// result. Configuration must be written only while idle; the block does not enforce this.
module message_segmenter_with_header_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [msu_pkg::LEN_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [msu_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [msu_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_is_header,
  output logic                         out_packet_end,
  output logic [1:0]                   out_status,
  output logic                         out_run_last
);
  import msu_pkg::*;

  // Configuration registers.
  logic [LEN_W-1:0]  msg_len_r;
  logic [BYTE_W-1:0] pkt_size_r;

  // Segmenter state.
  logic [LEN_W-1:0]  remaining_r, remaining_nxt;
  logic [BYTE_W-1:0] seq_r, seq_nxt;
  logic              first_r, first_nxt;
  logic [BYTE_W-1:0] fill_r, fill_nxt;

  // Result queue.
  result_t           q_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   count_r;

  result_t           res [MAX_RES];
  logic [1:0]        n_res;

  logic              in_xfer, out_xfer;
  logic              size_ok, is_last, pkt_end;
  logic [BYTE_W-1:0] cap;
  logic [BYTE_W:0]   fill_inc;
  logic [BYTE_W-1:0] flags;

  // Up to three results may be written in one cycle, so the queue must hold at most one
  // entry before an input transfer is taken.
  assign in_stall = (count_r > Q_CW'(1));
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_xfer  = out_valid && !out_stall;

  assign out_byte       = q_r[rd_ptr_r].out_byte;
  assign out_is_header  = q_r[rd_ptr_r].is_header;
  assign out_packet_end = q_r[rd_ptr_r].packet_end;
  assign out_status     = q_r[rd_ptr_r].status;
  assign out_run_last   = q_r[rd_ptr_r].run_last;

  assign size_ok  = (pkt_size_r > HDR_BYTES);
  assign cap      = pkt_size_r - HDR_BYTES;
  assign fill_inc = {1'b0, fill_r} + 9'd1;
  // The packet closes when it reaches the current capacity or the message runs out.
  assign pkt_end  = (fill_inc >= {1'b0, cap}) || (remaining_r == LEN_W'(1));
  assign is_last  = (remaining_r <= {8'd0, cap});
  assign flags    = (first_r ? FLAG_FIRST : 8'd0) | (is_last ? FLAG_LAST : 8'd0);

  // One pass of the segmenter for the item at the input.
  always_comb begin
    remaining_nxt = remaining_r;
    seq_nxt       = seq_r;
    first_nxt     = first_r;
    fill_nxt      = fill_r;
    n_res         = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end
    if (in_req_type == REQ_START) begin
      seq_nxt       = '0;
      first_nxt     = 1'b1;
      remaining_nxt = msg_len_r;
      fill_nxt      = '0;
      if (!size_ok) begin
        res[0].status   = STAT_TOO_SMALL;
        res[0].run_last = 1'b1;
        n_res           = 2'd1;
      end else if (msg_len_r == '0) begin
        // Empty message: a packet made only of its header.
        res[0].out_byte   = FLAG_FIRST | FLAG_LAST;
        res[0].is_header  = 1'b1;
        res[1].out_byte   = '0;
        res[1].is_header  = 1'b1;
        res[1].packet_end = 1'b1;
        res[1].run_last   = 1'b1;
        n_res             = 2'd2;
        seq_nxt           = 8'd1;
        first_nxt         = 1'b0;
      end
    end else begin
      if (!size_ok) begin
        res[0].status   = STAT_TOO_SMALL;
        res[0].run_last = 1'b1;
        n_res           = 2'd1;
      end else if (remaining_r == '0) begin
        res[0].status   = STAT_OVERRUN;
        res[0].run_last = 1'b1;
        n_res           = 2'd1;
      end else if (fill_r == '0) begin
        // First byte of a packet carries the header in front of it.
        res[0].out_byte   = flags;
        res[0].is_header  = 1'b1;
        res[1].out_byte   = seq_r;
        res[1].is_header  = 1'b1;
        res[2].out_byte   = in_data_byte;
        res[2].packet_end = pkt_end;
        res[2].run_last   = 1'b1;
        n_res             = 2'd3;
        seq_nxt           = seq_r + 8'd1;
        first_nxt         = 1'b0;
        remaining_nxt     = remaining_r - LEN_W'(1);
        fill_nxt          = pkt_end ? '0 : fill_inc[BYTE_W-1:0];
      end else begin
        res[0].out_byte   = in_data_byte;
        res[0].packet_end = pkt_end;
        res[0].run_last   = 1'b1;
        n_res             = 2'd1;
        remaining_nxt     = remaining_r - LEN_W'(1);
        fill_nxt          = pkt_end ? '0 : fill_inc[BYTE_W-1:0];
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r  <= '0;
      pkt_size_r <= PKT_SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MSG_LEN:  msg_len_r  <= cfg_wdata;
        CFG_PKT_SIZE: pkt_size_r <= cfg_wdata[BYTE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Segmenter state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      seq_r       <= '0;
      first_r     <= 1'b1;
      fill_r      <= '0;
    end else if (in_xfer) begin
      remaining_r <= remaining_nxt;
      seq_r       <= seq_nxt;
      first_r     <= first_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // Queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(n_res);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_r + (in_xfer ? Q_CW'(n_res) : Q_CW'(0))
                         - (out_xfer ? Q_CW'(1) : Q_CW'(0));
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < n_res) begin
          q_r[wr_ptr_r + Q_AW'(k)] <= res[k];
        end
      end
    end
  end

endmodule

// File: design/msu_checker.sv
`include "message_segmenter_with_header_unit_macros.svh"

module msu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_wr_en,
  input logic                       cfg_index,
  input logic [msu_pkg::LEN_W-1:0]  cfg_wdata,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_req_type,
  input logic [msu_pkg::BYTE_W-1:0] in_data_byte,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [msu_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_is_header,
  input logic                       out_packet_end,
  input logic [1:0]                 out_status,
  input logic                       out_run_last
);
  import msu_pkg::*;

  // With nothing queued the input must be open.
  `MSU_ASSERT_NOW(a_empty_ready, clk, rst_n, !out_valid, !in_stall, "stall with empty queue")

  // Error results are bare and close their item.
  `MSU_ASSERT_NOW(a_err_shape, clk, rst_n, out_valid && (out_status != STAT_OK), out_run_last && (out_byte == '0) && !out_is_header && !out_packet_end, "malformed error result")

  // A payload byte is always the last result of its item.
  `MSU_ASSERT_NOW(a_payload_last, clk, rst_n, out_valid && !out_is_header && (out_status == STAT_OK), out_run_last, "payload byte without run_last")

  // A stalled result holds.
  `MSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_status), "stalled result changed")

endmodule

bind message_segmenter_with_header_unit msu_checker u_msu_checker (.*);

// File: sim/message_segmenter_with_header_unit_tb.sv
`timescale 1ns / 100ps

// Testbench for the message segmenter. A scoreboard predicts every packet byte and
// error result from the transfers that the block accepts, and a checking process
// compares each result transfer field by field with the oldest prediction.
module message_segmenter_with_header_unit_tb;
  import msu_pkg::*;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 2;
  // The block drains its result queue one entry per cycle while the receiver does not stall;
  // wait_quiet adds SETTLE_CYCLES quiet cycles after the last result before a register write.
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 10;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int REPORT_LIMIT   = 10;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_wr_en      = 1'b0;
  logic              cfg_index      = CFG_MSG_LEN;
  logic [LEN_W-1:0]  cfg_wdata      = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_req_type    = REQ_START;
  logic [BYTE_W-1:0] in_data_byte   = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_is_header;
  logic              out_packet_end;
  logic [1:0]        out_status;
  logic              out_run_last;

  // Scoreboard copy of the block: its registers and its segmentation state.
  logic [LEN_W-1:0]  model_msg_len;
  logic [BYTE_W-1:0] model_pkt_size;
  logic [LEN_W-1:0]  bytes_left;
  logic [BYTE_W-1:0] seq_num;
  logic              first_pending;
  logic [BYTE_W-1:0] chunk_fill;
  result_t           expected_pkt_bytes[$];

  int items_sent        = 0;
  int bytes_checked     = 0;
  int cfg_writes        = 0;
  int fail_count        = 0;
  int cycle_count       = 0;
  int sender_idle_pct   = 36;
  int receiver_idle_pct = 45;
  int holdoff_requests  = 0;
  int holdoff_served    = 0;
  int holdoff_left      = 0;

  message_segmenter_with_header_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_header  (out_is_header),
    .out_packet_end (out_packet_end),
    .out_status     (out_status),
    .out_run_last   (out_run_last)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** message_segmenter_with_header_unit: FAILED **");
      $finish;
    end
  end

  // Receiver. A hold-off request from the stimulus keeps the output stalled for a long,
  // counted stretch; otherwise the receiver stalls at random at the current idle rate.
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_served + 1;
      holdoff_left   <= HOLDOFF_CYCLES;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  function automatic string describe(input result_t r);
    return $sformatf("byte %02h hdr %b end %b status %0d last %b",
                     r.out_byte, r.is_header, r.packet_end, r.status, r.run_last);
  endfunction

  function automatic void report_failure(input string msg);
    if (fail_count < REPORT_LIMIT)
      $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endfunction

  // Every result transfer is checked against the oldest predicted byte. Values are
  // sampled at the edge, before the block updates its outputs.
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen.out_byte   = out_byte;
      seen.is_header  = out_is_header;
      seen.packet_end = out_packet_end;
      seen.status     = out_status;
      seen.run_last   = out_run_last;
      if (expected_pkt_bytes.size() == 0) begin
        report_failure($sformatf("result with nothing expected: %s", describe(seen)));
      end else begin
        want = expected_pkt_bytes.pop_front();
        bytes_checked++;
        if (seen.out_byte !== want.out_byte || seen.is_header !== want.is_header ||
            seen.packet_end !== want.packet_end || seen.status !== want.status ||
            seen.run_last !== want.run_last)
          report_failure($sformatf("result %0d: expected %s, got %s", bytes_checked,
                                   describe(want), describe(seen)));
      end
    end
  end

  function automatic void queue_pkt_byte(input logic [BYTE_W-1:0] b, input logic hdr,
                                         input logic pend, input logic [1:0] st,
                                         input logic last);
    result_t r;
    r.out_byte   = b;
    r.is_header  = hdr;
    r.packet_end = pend;
    r.status     = st;
    r.run_last   = last;
    expected_pkt_bytes.push_back(r);
  endfunction

  // Works out the results of one accepted transfer and advances the segmentation
  // state. Errors carry zero payload fields and always close the transfer's results.
  function automatic void segment_predict(input logic req, input logic [BYTE_W-1:0] data);
    int unsigned       cap;
    logic              closes;
    logic [BYTE_W-1:0] flags;
    if (req == REQ_START) begin
      seq_num       = '0;
      first_pending = 1'b1;
      bytes_left    = model_msg_len;
      chunk_fill    = '0;
      if (model_pkt_size <= HDR_BYTES) begin
        queue_pkt_byte('0, 1'b0, 1'b0, STAT_TOO_SMALL, 1'b1);
      end else if (bytes_left == '0) begin
        // An empty message still gets a packet: a header that is both first and last.
        queue_pkt_byte(FLAG_FIRST | FLAG_LAST, 1'b1, 1'b0, STAT_OK, 1'b0);
        queue_pkt_byte(seq_num, 1'b1, 1'b1, STAT_OK, 1'b1);
        seq_num       = seq_num + 8'd1;
        first_pending = 1'b0;
      end
    end else if (model_pkt_size <= HDR_BYTES) begin
      queue_pkt_byte('0, 1'b0, 1'b0, STAT_TOO_SMALL, 1'b1);
    end else if (bytes_left == '0) begin
      queue_pkt_byte('0, 1'b0, 1'b0, STAT_OVERRUN, 1'b1);
    end else begin
      cap = {24'd0, model_pkt_size - HDR_BYTES};
      if (chunk_fill == '0) begin
        flags = first_pending ? FLAG_FIRST : '0;
        if (32'(bytes_left) <= cap)
          flags = flags | FLAG_LAST;
        queue_pkt_byte(flags, 1'b1, 1'b0, STAT_OK, 1'b0);
        queue_pkt_byte(seq_num, 1'b1, 1'b0, STAT_OK, 1'b0);
        seq_num       = seq_num + 8'd1;
        first_pending = 1'b0;
      end
      // A packet also closes when a smaller size was written while it was open.
      closes = (32'(chunk_fill) + 32'd1 >= cap) || (bytes_left == LEN_W'(1));
      queue_pkt_byte(data, 1'b0, closes, STAT_OK, 1'b1);
      bytes_left = bytes_left - LEN_W'(1);
      chunk_fill = closes ? '0 : chunk_fill + 8'd1;
    end
  endfunction

  // Offers one transfer, idling first at the sender's current rate, and holds it
  // until the block takes it. Valid stays high into the next call when no gap follows.
  task automatic send_transfer(input logic req, input logic [BYTE_W-1:0] data);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    segment_predict(req, data);
    items_sent++;
  endtask

  // The sender pauses until every predicted result has arrived.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_pkt_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
    wait_quiet();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MSG_LEN)
      model_msg_len = value;
    else
      model_pkt_size = value[BYTE_W-1:0];
    cfg_writes++;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    receiver_idle_pct <= recv_pct;
  endtask

  // Reset values: a byte before any start is beyond the message, and a start with the
  // reset length of zero gives a header-only packet, every time with sequence zero.
  task automatic test_reset_defaults();
    send_transfer(REQ_DATA, 8'hC3);
    send_transfer(REQ_START, 8'h00);
    send_transfer(REQ_START, 8'hFF);
  endtask

  // Sizes of two bytes or less leave no room for payload. Such transfers only report
  // the error; a payload byte leaves the open packet alone, a start still restarts.
  task automatic test_undersized_packets();
    write_reg(CFG_MSG_LEN, 16'd3);
    write_reg(CFG_PKT_SIZE, 16'd5);
    send_transfer(REQ_START, 8'h00);
    send_transfer(REQ_DATA, 8'h11);
    write_reg(CFG_PKT_SIZE, 16'd0);
    send_transfer(REQ_DATA, 8'h22);
    // Only the low byte of the write data belongs to the size register.
    write_reg(CFG_PKT_SIZE, 16'hFF02);
    send_transfer(REQ_DATA, 8'h33);
    write_reg(CFG_PKT_SIZE, 16'd5);
    send_transfer(REQ_DATA, 8'h44);
    write_reg(CFG_PKT_SIZE, 16'd1);
    send_transfer(REQ_START, 8'h00);
    write_reg(CFG_PKT_SIZE, 16'd5);
    send_transfer(REQ_DATA, 8'h55);
  endtask

  // Five bytes in packets of two payload bytes, then one byte too many.
  task automatic test_basic_segmentation();
    write_reg(CFG_MSG_LEN, 16'd5);
    write_reg(CFG_PKT_SIZE, 16'd4);
    send_transfer(REQ_START, 8'h00);
    send_transfer(REQ_DATA, 8'h00);
    send_transfer(REQ_DATA, 8'hFF);
    send_transfer(REQ_DATA, 8'h5A);
    send_transfer(REQ_DATA, 8'hA5);
    send_transfer(REQ_DATA, 8'h7E);
    send_transfer(REQ_DATA, 8'h01);
  endtask

  // Shrinking the size closes the open packet on its next byte; growing it lets the
  // packet run on. The length register only matters at the next start.
  task automatic test_size_change_mid_packet();
    write_reg(CFG_MSG_LEN, 16'd12);
    write_reg(CFG_PKT_SIZE, 16'd10);
    send_transfer(REQ_START, 8'h00);
    repeat (4) send_transfer(REQ_DATA, 8'($urandom_range(255)));
    write_reg(CFG_PKT_SIZE, 16'd5);
    send_transfer(REQ_DATA, 8'h80);
    send_transfer(REQ_DATA, 8'h08);
    write_reg(CFG_PKT_SIZE, 16'd255);
    send_transfer(REQ_DATA, 8'hF0);
    write_reg(CFG_MSG_LEN, 16'hFFFF);
    send_transfer(REQ_DATA, 8'h0F);
    send_transfer(REQ_START, 8'h00);
    send_transfer(REQ_DATA, 8'h3C);
    write_reg(CFG_MSG_LEN, 16'd0);
    send_transfer(REQ_START, 8'h00);
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering first and
  // middle bytes, so the result queue fills and the block stalls its input.
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = sender_idle_pct;
    write_reg(CFG_MSG_LEN, 16'd30);
    write_reg(CFG_PKT_SIZE, 16'd4);
    sender_idle_pct = 0;
    holdoff_requests <= holdoff_requests + 1;
    send_transfer(REQ_START, 8'h00);
    repeat (30) send_transfer(REQ_DATA, 8'($urandom_range(255)));
    wait_quiet();
    sender_idle_pct = saved_pct;
  endtask

  // One payload byte per packet for more than 256 packets wraps the sequence number.
  task automatic test_sequence_wrap();
    write_reg(CFG_MSG_LEN, 16'd260);
    write_reg(CFG_PKT_SIZE, 16'd3);
    send_transfer(REQ_START, 8'($urandom_range(255)));
    repeat (260) send_transfer(REQ_DATA, 8'($urandom_range(255)));
  endtask

  // Mostly whole messages with random sizes, lengths and content. Some are cut short
  // by a stray start or by the next message, some run past their length, and a few
  // see the packet size change while a packet is open.
  task automatic test_random_messages(input int n_items);
    int               target;
    int               pick;
    int               msg_len;
    int               n_bytes;
    int               n_extra;
    logic [LEN_W-1:0] wdata;
    target = items_sent + n_items;
    while (items_sent < target) begin
      wdata = LEN_W'($urandom);
      pick  = $urandom_range(99);
      if (pick < 8)
        wdata[BYTE_W-1:0] = 8'($urandom_range(HDR_BYTES));
      else if (pick < 18)
        wdata[BYTE_W-1:0] = 8'($urandom_range(200, 255));
      else
        wdata[BYTE_W-1:0] = 8'($urandom_range(3, 12));
      write_reg(CFG_PKT_SIZE, wdata);
      pick = $urandom_range(99);
      if (pick < 10)
        msg_len = 0;
      else if (pick < 16)
        msg_len = $urandom_range(1024, 65535);
      else
        msg_len = $urandom_range(1, 24);
      write_reg(CFG_MSG_LEN, LEN_W'(msg_len));
      send_transfer(REQ_START, 8'($urandom_range(255)));
      n_bytes = (msg_len > 24) ? $urandom_range(1, 8) : msg_len;
      pick    = $urandom_range(99);
      if (pick < 15)
        n_bytes = $urandom_range(0, n_bytes);
      n_extra = (pick >= 15 && pick < 30) ? $urandom_range(1, 3) : 0;
      repeat (n_bytes + n_extra) begin
        pick = $urandom_range(99);
        if (pick < 4)
          write_reg(CFG_PKT_SIZE, LEN_W'($urandom_range(3, 12)));
        else if (pick < 7)
          send_transfer(REQ_START, 8'($urandom_range(255)));
        send_transfer(REQ_DATA, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    model_msg_len  = '0;
    model_pkt_size = PKT_SIZE_RESET;
    bytes_left     = '0;
    seq_num        = '0;
    first_pending  = 1'b1;
    chunk_fill     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks and the first random messages run with both sides idling, the
    // sender at an idle rate of 36 percent and the receiver at 45 percent.
    test_reset_defaults();
    test_undersized_packets();
    test_basic_segmentation();
    test_size_change_mid_packet();
    test_backpressure();
    test_random_messages(50);

    set_idle(45, 36);
    test_sequence_wrap();
    test_random_messages(50);

    set_idle(0, 0);
    test_random_messages(50);

    in_valid <= 1'b0;
    while (expected_pkt_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input transfers and checked %0d results over %0d register writes.",
             items_sent, bytes_checked, cfg_writes);
    $display("Covered empty and undersized packets, overruns, resizing and sequence wrap.");
    if (fail_count == 0 && expected_pkt_bytes.size() == 0) begin
      $display("** message_segmenter_with_header_unit: PASSED **");
    end else begin
      $display("%0d failures, %0d results still expected.", fail_count,
               expected_pkt_bytes.size());
      $display("** message_segmenter_with_header_unit: FAILED **");
    end
    $finish;
  end

endmodule
